### src/psec_pkg.sv
// ---------------------------------------------------------------------------
// psec_pkg: shared types and constants of the phase sweep edge calibrator
// Request and response layouts, command and status codes, and the fixed
// arithmetic constants of the phase sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psec_pkg;

   // Field widths fixed by the request and response formats
   localparam int unsigned PHASE_FIELD_W = 11;
   localparam int unsigned GEN_FIELD_W   = 8;
   localparam int unsigned COUNT_W       = 16;
   localparam int unsigned TAG_W         = 22;
   localparam int unsigned FRAC_W        = 14;
   localparam int unsigned ABS_W         = 21;
   localparam int unsigned DELTA_W       = 23;
   localparam int unsigned REQ_DATA_W    = 64;
   localparam int unsigned RSP_DATA_W    = 48;

   // Sweep constants, in shifter steps (56 steps per 800 ps period)
   localparam int unsigned STEPS_PER_PERIOD = 56;
   localparam int unsigned QUARTER_STEPS    = STEPS_PER_PERIOD / 4;
   localparam int unsigned PHASE_LIMIT      = 21 * STEPS_PER_PERIOD;
   localparam int unsigned WRAP_QUARTERS    = (20 * STEPS_PER_PERIOD) / QUARTER_STEPS;
   localparam logic [COUNT_W-1:0] SAMPLES_DEFAULT = 16'd10240;

   // Divide by 14 as multiply by reciprocal; exact for any 16-bit dividend
   localparam int unsigned DIV_IN_W   = 16;
   localparam int unsigned DIV_SHIFT  = 20;
   localparam logic [16:0] DIV_MULT   = 17'd74899;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_RESET   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_SHIFT   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STAT_IDLE     = 2'd0,
      STAT_SWEEPING = 2'd1,
      STAT_DONE     = 2'd2,
      STAT_ERROR    = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      OP_POLL  = 1'b0,
      OP_START = 1'b1
   } opcode_type;

   // One request as held in the input register
   typedef struct packed {
      opcode_type               opcode;
      logic                     locked;
      logic [PHASE_FIELD_W-1:0] shift_phase;
      logic [GEN_FIELD_W-1:0]   result_generation;
      logic [COUNT_W-1:0]       result_value;
      logic [TAG_W-1:0]         tag_reference;
   } request_type;

   // One response as held in the output register
   typedef struct packed {
      command_type        command;
      status_type         status;
      logic [ABS_W-1:0]   absolute_phase;
      logic [DELTA_W-1:0] tag_delta;
   } response_type;

   // Picoseconds within a 200 ps quarter for a phase remainder mod 14:
   // floor(r * 800 / 56)
   function automatic logic [7:0] quarter_ps(input logic [3:0] r);
      logic [7:0] ps;
      unique case (r)
         4'd0:    ps = 8'd0;
         4'd1:    ps = 8'd14;
         4'd2:    ps = 8'd28;
         4'd3:    ps = 8'd42;
         4'd4:    ps = 8'd57;
         4'd5:    ps = 8'd71;
         4'd6:    ps = 8'd85;
         4'd7:    ps = 8'd100;
         4'd8:    ps = 8'd114;
         4'd9:    ps = 8'd128;
         4'd10:   ps = 8'd142;
         4'd11:   ps = 8'd157;
         4'd12:   ps = 8'd171;
         4'd13:   ps = 8'd185;
         default: ps = 8'd0;
      endcase
      return ps;
   endfunction

endpackage

### src/psec_finish.sv
// ---------------------------------------------------------------------------
// psec_finish: edge phase arithmetic
// Averages the last zero phase and the first full phase, applies the
// quarter-period skew rule and wrap, and forms absolute phase and tag delta.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psec_finish
   import psec_pkg::*;
#(
   parameter int unsigned PHASE_WIDTH = 11
) (
   input  logic [PHASE_WIDTH-1:0] zero_phase,
   input  logic [PHASE_WIDTH-1:0] edge_phase,
   input  logic [TAG_W-1:0]       tag_reference,
   output logic [ABS_W-1:0]       absolute_phase,
   output logic [DELTA_W-1:0]     tag_delta
);

   logic [PHASE_WIDTH:0]   phase_sum;
   logic [PHASE_WIDTH-1:0] mid_phase;
   logic [DIV_IN_W-1:0]    mid_ext;
   logic [DIV_IN_W+16:0]   recip_prod;
   logic [PHASE_WIDTH-1:0] quarters;
   logic [DIV_IN_W-1:0]    quarters_x14;
   logic [DIV_IN_W-1:0]    remainder_full;
   logic [7:0]             phase_ps;
   logic [FRAC_W-1:0]      sub_tag;
   logic [FRAC_W+7:0]      tag_prod;
   logic [7:0]             tag_ps;
   logic                   skew_add;
   logic [PHASE_WIDTH-1:0] quarters_adj;
   logic [PHASE_WIDTH-1:0] quarters_fin;

   // Midpoint of the two phases
   assign phase_sum = {1'b0, zero_phase} + {1'b0, edge_phase};
   assign mid_phase = phase_sum[PHASE_WIDTH:1];

   // Quarter index and remainder: divide by 14
   assign mid_ext        = DIV_IN_W'(mid_phase);
   assign recip_prod     = mid_ext * DIV_MULT;
   assign quarters       = PHASE_WIDTH'(recip_prod >> DIV_SHIFT);
   assign quarters_x14   = (DIV_IN_W'(quarters) << 4) - (DIV_IN_W'(quarters) << 1);
   assign remainder_full = mid_ext - quarters_x14;
   assign phase_ps       = quarter_ps(remainder_full[3:0]);

   // Tag position within its 200 ps quarter
   assign sub_tag  = tag_reference[FRAC_W-1:0];
   assign tag_prod = sub_tag * 8'd200;
   assign tag_ps   = tag_prod[FRAC_W+7:FRAC_W];

   // Skew rule adds a quarter; wrap by 20 periods (80 quarters) once
   assign skew_add     = (phase_ps >= tag_ps);
   assign quarters_adj = quarters + PHASE_WIDTH'(skew_add);

   always_comb begin
      if (quarters_adj >= PHASE_WIDTH'(WRAP_QUARTERS)) begin
         quarters_fin = quarters_adj - PHASE_WIDTH'(WRAP_QUARTERS);
      end else begin
         quarters_fin = quarters_adj;
      end
   end

   assign absolute_phase = {quarters_fin[ABS_W-FRAC_W-1:0], sub_tag};
   assign tag_delta      = DELTA_W'(tag_reference) - DELTA_W'(absolute_phase);

endmodule

### src/psec_seq.sv
// ---------------------------------------------------------------------------
// psec_seq: sweep sequencer
// Holds the sweep state and the sample count register, and turns each
// request into one response while updating the state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psec_seq
   import psec_pkg::*;
#(
   parameter int unsigned PHASE_WIDTH = 11,
   parameter int unsigned GEN_WIDTH   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata,
   input  logic               step,
   input  request_type        request,
   output response_type       response
);

   typedef enum logic [4:0] {
      MODE_IDLE         = 5'b00001,
      MODE_WAIT_LOCK    = 5'b00010,
      MODE_WAIT_MEASURE = 5'b00100,
      MODE_DONE         = 5'b01000,
      MODE_ERROR        = 5'b10000
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [COUNT_W-1:0]     sample_count_ff;
   logic [PHASE_WIDTH-1:0] zero_phase_ff, zero_phase_in;
   logic                   zero_seen_ff, zero_seen_in;
   logic [GEN_WIDTH-1:0]   gen_seen_ff, gen_seen_in;
   logic [ABS_W-1:0]       phase_result_ff, phase_result_in;
   logic [DELTA_W-1:0]     delta_result_ff, delta_result_in;

   logic [PHASE_WIDTH-1:0] phase;
   logic [15:0]            gen_ext;
   logic [GEN_WIDTH-1:0]   gen;
   logic                   count_zero;
   logic [PHASE_WIDTH-1:0] zero_phase_upd;
   logic                   zero_seen_upd;
   logic [ABS_W-1:0]       fin_abs;
   logic [DELTA_W-1:0]     fin_delta;
   command_type            command;
   status_type             status;

   // Only the low PHASE_WIDTH / GEN_WIDTH bits of the fields count
   assign phase   = PHASE_WIDTH'(request.shift_phase);
   assign gen_ext = 16'(request.result_generation);
   assign gen     = gen_ext[GEN_WIDTH-1:0];

   // A zero count is recorded before the full-count check
   assign count_zero     = (request.result_value == '0);
   assign zero_phase_upd = count_zero ? phase : zero_phase_ff;
   assign zero_seen_upd  = zero_seen_ff | count_zero;

   psec_finish #(
      .PHASE_WIDTH (PHASE_WIDTH)
   ) u_finish (
      .zero_phase     (zero_phase_upd),
      .edge_phase     (phase),
      .tag_reference  (request.tag_reference),
      .absolute_phase (fin_abs),
      .tag_delta      (fin_delta)
   );

   // Next state and command for one request
   always_comb begin
      mode_in         = mode_ff;
      zero_phase_in   = zero_phase_ff;
      zero_seen_in    = zero_seen_ff;
      gen_seen_in     = gen_seen_ff;
      phase_result_in = phase_result_ff;
      delta_result_in = delta_result_ff;
      command         = CMD_NONE;
      if (request.opcode == OP_START) begin
         command         = CMD_RESET;
         zero_phase_in   = '0;
         zero_seen_in    = 1'b0;
         phase_result_in = '0;
         delta_result_in = '0;
         mode_in         = MODE_WAIT_LOCK;
      end else begin
         unique case (mode_ff)
            MODE_WAIT_LOCK: begin
               command = CMD_RELEASE;
               if (request.locked) begin
                  gen_seen_in = gen;
                  mode_in     = MODE_WAIT_MEASURE;
               end
            end
            MODE_WAIT_MEASURE: begin
               if (gen != gen_seen_ff) begin
                  zero_phase_in = zero_phase_upd;
                  zero_seen_in  = zero_seen_upd;
                  if (request.result_value >= sample_count_ff && zero_seen_upd) begin
                     phase_result_in = fin_abs;
                     delta_result_in = fin_delta;
                     mode_in         = MODE_DONE;
                  end else if (phase == PHASE_WIDTH'(PHASE_LIMIT)) begin
                     mode_in = MODE_ERROR;
                  end else begin
                     command = CMD_SHIFT;
                     mode_in = MODE_WAIT_LOCK;
                  end
               end
            end
            MODE_IDLE, MODE_DONE, MODE_ERROR: begin
               command = CMD_NONE;
            end
            default: begin
               command = CMD_NONE;
            end
         endcase
      end
   end

   // Status follows the mode after this request
   always_comb begin
      unique case (mode_in)
         MODE_IDLE:  status = STAT_IDLE;
         MODE_DONE:  status = STAT_DONE;
         MODE_ERROR: status = STAT_ERROR;
         default:    status = STAT_SWEEPING;
      endcase
   end

   always_comb begin
      response.command = command;
      response.status  = status;
      if (status == STAT_DONE) begin
         response.absolute_phase = phase_result_in;
         response.tag_delta      = delta_result_in;
      end else begin
         response.absolute_phase = '0;
         response.tag_delta      = '0;
      end
   end

   // Sample count register
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLES_DEFAULT;
      end else if (csr_we) begin
         sample_count_ff <= csr_wdata;
      end
   end

   // Sweep state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         zero_phase_ff   <= '0;
         zero_seen_ff    <= 1'b0;
         gen_seen_ff     <= '0;
         phase_result_ff <= '0;
         delta_result_ff <= '0;
      end else if (step) begin
         mode_ff         <= mode_in;
         zero_phase_ff   <= zero_phase_in;
         zero_seen_ff    <= zero_seen_in;
         gen_seen_ff     <= gen_seen_in;
         phase_result_ff <= phase_result_in;
         delta_result_ff <= delta_result_in;
      end
   end

   // A start always answers reset-shifter while sweeping
   a_start_resets: assert property (@(posedge clock) disable iff (reset)
      step && request.opcode == OP_START |->
         response.command == CMD_RESET && response.status == STAT_SWEEPING)
      else $error("start request did not restart the sweep");

   // Leaving done or error takes a start
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      step && request.opcode == OP_POLL && (mode_ff == MODE_DONE || mode_ff == MODE_ERROR)
         |=> mode_ff == $past(mode_ff))
      else $error("poll changed a finished sweep");

   // A finished sweep never has a pending zero record missing
   a_done_needs_zero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DONE |-> zero_seen_ff)
      else $error("sweep done without a recorded zero phase");

endmodule

### src/phase_sweep_edge_calibrator.sv
// ---------------------------------------------------------------------------
// phase_sweep_edge_calibrator: phase sweep edge calibrator top level
// Input register, sweep sequencer and output register on stream channels.
// ---------------------------------------------------------------------------
// Each request is a start or a poll snapshot of the phase shifter and its
// sample counter; each request yields exactly one response with the shifter
// command, the sweep status and, once done, the absolute phase and tag
// delta. A request is held in the input register, and its response is then
// written into the output register and offered from there; while the output
// register is stalled the request waits in the input register. One request
// per clock is sustained while the response side keeps up: the sequencer
// updates its state as each request is stepped. The sample count
// register is written through csr_we / csr_wdata and takes effect on the
// next request.
`timescale 1ns / 1ps

module phase_sweep_edge_calibrator
   import psec_pkg::*;
#(
   parameter int unsigned PHASE_WIDTH = 11,
   parameter int unsigned GEN_WIDTH   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] locked, [11:1] shift_phase, [19:12] result_generation,
   // [35:20] result_value, [57:36] tag_reference, [63:58] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                  req_tuser,
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] command, [3:2] status, [24:4] absolute_phase, [47:25] tag_delta
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata
);

   logic         in_valid_ff;
   request_type  in_req_ff;
   logic         out_valid_ff;
   response_type out_rsp_ff;
   logic         advance;
   logic         step;
   request_type  req_unpacked;
   response_type seq_rsp;

   // Pipeline moves when the output register is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   always_comb begin
      req_unpacked.opcode            = opcode_type'(req_tuser);
      req_unpacked.locked            = req_tdata[0];
      req_unpacked.shift_phase       = req_tdata[11:1];
      req_unpacked.result_generation = req_tdata[19:12];
      req_unpacked.result_value      = req_tdata[35:20];
      req_unpacked.tag_reference     = req_tdata[57:36];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff <= req_unpacked;
      end
   end

   psec_seq #(
      .PHASE_WIDTH (PHASE_WIDTH),
      .GEN_WIDTH   (GEN_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (step),
      .request   (in_req_ff),
      .response  (seq_rsp)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_rsp_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_rsp_ff.tag_delta, out_rsp_ff.absolute_phase,
                        out_rsp_ff.status, out_rsp_ff.command};

   // A request waiting on a stalled output is kept
   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("request lost in input register");

   // Every processed request lands in the output register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed request produced no response");

   // Results are only shown while done
   a_results_done_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.status != STAT_DONE |->
         out_rsp_ff.absolute_phase == '0 && out_rsp_ff.tag_delta == '0)
      else $error("results shown outside done status");

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the phase sweep edge calibrator
// A directed table walks the sweep through start, lock, zero and full counts,
// the phase limit and the wrap, then random sweeps run under several sample
// count settings with random idling on both channels, but for one setting held steady.
// Every response is compared field by field with its typed row or a behavioral model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import psec_pkg::*;

   localparam int unsigned IDLE_PERCENT      = 20;
   localparam int unsigned SETTLE_CYCLES     = 4;
   localparam int unsigned WATCHDOG_LIMIT    = 1000;
   localparam int unsigned ITEMS_PER_SETTING = 120;
   localparam int unsigned PERIOD_PS         = 800;
   localparam int unsigned QUARTER_PS        = 200;
   localparam int unsigned WRAP_STEPS        = 20 * STEPS_PER_PERIOD;
   localparam int unsigned PHASE_SPAN        = 1 << PHASE_FIELD_W;
   localparam logic [TAG_W-1:0] TAG_MAX      = '1;

   // Sample count settings, one per random phase; the marked one is drawn
   localparam int unsigned RANDOM_SETTING = 2;
   localparam logic [COUNT_W-1:0] SAMPLE_SETTINGS [6] =
      '{16'd1, 16'd65535, 16'd0, 16'd0, 16'd200, 16'd10240};

   typedef enum logic [4:0] {
      MDL_IDLE         = 5'b00001,
      MDL_LOCK_WAIT    = 5'b00010,
      MDL_MEASURE_WAIT = 5'b00100,
      MDL_FINISHED     = 5'b01000,
      MDL_FAILED       = 5'b10000
   } model_mode_type;

   typedef struct packed {
      request_type  request;
      logic         typed;
      response_type response;
   } directed_row_type;

   localparam response_type PREDICTED = '0;

   // Directed sweep; typed rows carry their response, the rest use the model
   localparam directed_row_type DIRECTED [25] = '{
      '{'{OP_POLL,  1'b1, 11'd2047, 8'd255, 16'd65535, TAG_MAX}, 1'b1,
        '{CMD_NONE, STAT_IDLE, 21'd0, 23'd0}},
      '{'{OP_START, 1'b0, 11'd0, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_RESET, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd0, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd100, 8'd5, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd100, 8'd5, 16'd0, 22'd0}, 1'b1,
        '{CMD_NONE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd100, 8'd6, 16'd0, 22'd0}, 1'b1,
        '{CMD_SHIFT, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd101, 8'd6, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd101, 8'd7, 16'd10239, 22'd0}, 1'b1,
        '{CMD_SHIFT, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd102, 8'd7, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd102, 8'd8, 16'd10240, 22'h012345}, 1'b0, PREDICTED},
      '{'{OP_POLL,  1'b1, 11'd555, 8'd99, 16'd0, 22'h2AAAAA}, 1'b0, PREDICTED},
      '{'{OP_START, 1'b1, 11'd2047, 8'd255, 16'd65535, TAG_MAX}, 1'b1,
        '{CMD_RESET, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd1176, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd1176, 8'd1, 16'd65535, 22'd0}, 1'b1,
        '{CMD_NONE, STAT_ERROR, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd0, 8'd2, 16'd0, TAG_MAX}, 1'b1,
        '{CMD_NONE, STAT_ERROR, 21'd0, 23'd0}},
      '{'{OP_START, 1'b0, 11'd0, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_RESET, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd2047, 8'd255, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd2047, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_SHIFT, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd2047, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd2047, 8'd1, 16'd65535, 22'd0}, 1'b0, PREDICTED},
      '{'{OP_START, 1'b0, 11'd0, 8'd0, 16'd0, 22'd0}, 1'b1,
        '{CMD_RESET, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd1120, 8'd10, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd1120, 8'd11, 16'd0, 22'd0}, 1'b1,
        '{CMD_SHIFT, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b1, 11'd1120, 8'd11, 16'd0, 22'd0}, 1'b1,
        '{CMD_RELEASE, STAT_SWEEPING, 21'd0, 23'd0}},
      '{'{OP_POLL,  1'b0, 11'd1120, 8'd12, 16'd40000, TAG_MAX}, 1'b0, PREDICTED}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [0] locked, [11:1] shift_phase,
                                               // [19:12] result_generation,
                                               // [35:20] result_value,
                                               // [57:36] tag_reference
   logic                  req_tuser   = 1'b0; // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [1:0] command, [3:2] status,
                                               // [24:4] absolute_phase,
                                               // [47:25] tag_delta
   logic                  csr_we      = 1'b0;
   logic [COUNT_W-1:0]    csr_wdata   = '0;

   // Sequencer model state
   model_mode_type     model_mode         = MDL_IDLE;
   logic [COUNT_W-1:0] samples_per_step   = SAMPLES_DEFAULT;
   logic [10:0]        before_edge_phase  = '0;
   logic               before_edge_seen   = 1'b0;
   logic [7:0]         latched_generation = '0;
   logic [ABS_W-1:0]   latched_phase      = '0;
   logic [DELTA_W-1:0] latched_delta      = '0;

   response_type pending_responses [$];
   int unsigned  mismatch_count = 0;
   int unsigned  response_index = 0;
   int unsigned  stall_cycles   = 0;
   bit           steady         = 1'b0;

   // Random sweep cursor: current shifter phase and where the edge sits
   int unsigned  sweep_phase = 0;
   int unsigned  edge_phase  = 0;

   phase_sweep_edge_calibrator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One sequencer step: update the model state, return the response
   task automatic edge_search_step(input request_type rq, output response_type rs);
      int unsigned mid;
      int unsigned frac;
      int unsigned phase_ps;
      int unsigned tag_ps;
      int unsigned abs_full;
      command_type cmd;
      status_type  st;
      cmd = CMD_NONE;
      if (rq.opcode == OP_START) begin
         cmd = CMD_RESET;
         before_edge_seen  = 1'b0;
         before_edge_phase = '0;
         latched_phase     = '0;
         latched_delta     = '0;
         model_mode        = MDL_LOCK_WAIT;
      end else if (model_mode == MDL_LOCK_WAIT) begin
         cmd = CMD_RELEASE;
         if (rq.locked) begin
            latched_generation = rq.result_generation;
            model_mode         = MDL_MEASURE_WAIT;
         end
      end else if (model_mode == MDL_MEASURE_WAIT &&
                   rq.result_generation != latched_generation) begin
         // zero count is recorded before the full count is tested
         if (rq.result_value == 0) begin
            before_edge_phase = rq.shift_phase;
            before_edge_seen  = 1'b1;
         end
         if (rq.result_value >= samples_per_step && before_edge_seen) begin
            mid      = 32'(before_edge_phase);
            mid      = (mid + 32'(rq.shift_phase)) >> 1;
            frac     = 32'(rq.tag_reference[FRAC_W-1:0]);
            phase_ps = (mid * PERIOD_PS / STEPS_PER_PERIOD) % QUARTER_PS;
            tag_ps   = (frac * QUARTER_PS) >> FRAC_W;
            // skew rule, then a single wrap
            if (phase_ps >= tag_ps)
               mid += QUARTER_STEPS;
            if (mid >= WRAP_STEPS)
               mid -= WRAP_STEPS;
            abs_full      = ((mid / QUARTER_STEPS) << FRAC_W) | frac;
            latched_phase = abs_full[ABS_W-1:0];
            latched_delta = DELTA_W'(rq.tag_reference) - DELTA_W'(latched_phase);
            model_mode    = MDL_FINISHED;
         end else if (rq.shift_phase == PHASE_LIMIT) begin
            model_mode = MDL_FAILED;
         end else begin
            cmd        = CMD_SHIFT;
            model_mode = MDL_LOCK_WAIT;
         end
      end
      unique case (model_mode)
         MDL_IDLE:     st = STAT_IDLE;
         MDL_FINISHED: st = STAT_DONE;
         MDL_FAILED:   st = STAT_ERROR;
         default:      st = STAT_SWEEPING;
      endcase
      rs.command        = cmd;
      rs.status         = st;
      rs.absolute_phase = (st == STAT_DONE) ? latched_phase : '0;
      rs.tag_delta      = (st == STAT_DONE) ? latched_delta : '0;
   endtask

   // Drive one request, wait for acceptance, queue its response
   task automatic send_request(input request_type rq, input logic typed,
                               input response_type typed_rsp);
      response_type rs;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.opcode;
      req_tdata  <= {{(REQ_DATA_W - 58){1'b0}}, rq.tag_reference, rq.result_value,
                     rq.result_generation, rq.shift_phase, rq.locked};
      do @(posedge clock); while (!req_tready);
      edge_search_step(rq, rs);
      pending_responses.push_back(typed ? typed_rsp : rs);
   endtask

   // Hold off requests until every response is back, then let the pipe settle
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("response %0d: %s got 0x%0h expected 0x%0h",
               response_index, what, got, want);
   endtask

   // Response side stall pattern
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Response checker
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_tdata), '0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[1:0] != want.command)
               report_mismatch("command", 64'(rsp_tdata[1:0]), 64'(want.command));
            if (rsp_tdata[3:2] != want.status)
               report_mismatch("status", 64'(rsp_tdata[3:2]), 64'(want.status));
            if (rsp_tdata[24:4] != want.absolute_phase)
               report_mismatch("absolute_phase", 64'(rsp_tdata[24:4]),
                               64'(want.absolute_phase));
            if (rsp_tdata[47:25] != want.tag_delta)
               report_mismatch("tag_delta", 64'(rsp_tdata[47:25]), 64'(want.tag_delta));
         end
         response_index++;
      end
   end

   // Watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL phase_sweep_edge_calibrator");
            $finish;
         end
      end
   end

   initial begin : stimulus
      request_type        rq;
      int unsigned        step;
      logic [COUNT_W-1:0] setting;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed sweep at the reset sample count
      foreach (DIRECTED[i])
         send_request(DIRECTED[i].request, DIRECTED[i].typed, DIRECTED[i].response);

      // random sweeps, one phase per sample count setting
      for (int p = 0; p < $size(SAMPLE_SETTINGS); p++) begin
         setting = SAMPLE_SETTINGS[p];
         if (p == RANDOM_SETTING)
            setting = 16'($urandom_range(65534, 2));
         drain_responses();
         csr_we    <= 1'b1;
         csr_wdata <= setting;
         @(posedge clock);
         csr_we           <= 1'b0;
         samples_per_step  = setting;
         steady            = (p == RANDOM_SETTING);

         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            rq.opcode            = OP_POLL;
            rq.locked            = 1'($urandom_range(1));
            rq.shift_phase       = 11'($urandom_range(PHASE_SPAN - 1));
            rq.result_generation = 8'($urandom_range(255));
            rq.result_value      = 16'($urandom_range(65535));
            case ($urandom_range(7))
               0:       rq.tag_reference = '0;
               1:       rq.tag_reference = TAG_MAX;
               2:       rq.tag_reference = {8'($urandom_range(255)), {FRAC_W{1'b1}}};
               default: rq.tag_reference = 22'($urandom_range(TAG_MAX));
            endcase

            if ($urandom_range(99) < 8) begin
               // noise: an arbitrary request, now and then a start
               if ($urandom_range(3) == 0)
                  rq.opcode = OP_START;
            end else begin
               case (model_mode)
                  MDL_LOCK_WAIT: begin
                     rq.locked      = ($urandom_range(3) != 0);
                     rq.shift_phase = 11'(sweep_phase);
                  end
                  MDL_MEASURE_WAIT: begin
                     rq.shift_phase = 11'(sweep_phase);
                     if ($urandom_range(4) == 0) begin
                        rq.result_generation = latched_generation;
                     end else begin
                        rq.result_generation = latched_generation + 8'($urandom_range(255, 1));
                        // zeros before the edge, full counts after it, now and then a partial count
                        if ($urandom_range(3) == 0 && samples_per_step >= 2)
                           rq.result_value = 16'($urandom_range(samples_per_step - 1, 1));
                        else if (sweep_phase < edge_phase)
                           rq.result_value = '0;
                        else
                           rq.result_value = 16'($urandom_range(65535, samples_per_step));
                        step = $urandom_range(24, 1);
                        if (sweep_phase < PHASE_LIMIT && sweep_phase + step > PHASE_LIMIT &&
                            $urandom_range(1))
                           sweep_phase = PHASE_LIMIT;
                        else
                           sweep_phase = (sweep_phase + step) % PHASE_SPAN;
                     end
                  end
                  default: begin
                     if ($urandom_range(1))
                        rq.opcode = OP_START;
                  end
               endcase
            end

            // a start places a fresh sweep
            if (rq.opcode == OP_START) begin
               case ($urandom_range(3))
                  0:       sweep_phase = 0;
                  1:       sweep_phase = $urandom_range(PHASE_LIMIT, PHASE_LIMIT - 80);
                  default: sweep_phase = $urandom_range(PHASE_LIMIT);
               endcase
               edge_phase = sweep_phase + $urandom_range(60, 1);
            end
            send_request(rq, 1'b0, PREDICTED);
         end
      end

      drain_responses();
      if (mismatch_count == 0 && pending_responses.size() == 0)
         $display("PASS phase_sweep_edge_calibrator");
      else
         $display("FAIL phase_sweep_edge_calibrator");
      $finish;
   end

endmodule
